@@ sv/vnr_pkg.sv @@
// ----------------------------------------------------------------------------
// vnr_pkg
// Shared constants for the vertex normal pipeline.
// ----------------------------------------------------------------------------
package vnr_pkg;

  localparam int POINT_WIDTH      = 63;
  localparam int NORMAL_WIDTH     = 16;
  localparam int COORD_WIDTH_DEF  = 21;
  localparam int NORMAL_FRAC_DEF  = 14;
  localparam int FACE_FRAC        = 28;

  // normalized magnitudes have their top bit at UNIT_TOP
  localparam int UNIT_W           = 30;
  localparam int UNIT_TOP         = UNIT_W - 1;
  localparam int SUMSQ_W          = 2 * UNIT_W + 2;
  localparam int ROOT_W           = UNIT_W + 1;
  localparam int SQRT_STAGES      = ROOT_W;

  // abs, lead-one, shift, square, sum, sqrt, dividend, output
  localparam int UNIT_BASE_LAT    = 5 + SQRT_STAGES + 1 + 1 + 1;

endpackage

@@ sv/vnr_unitize.sv @@
// ----------------------------------------------------------------------------
// vnr_unitize
// Pipelined scaling of a signed 3-vector to unit length with FRAC fraction
// bits: normalize, square and sum, bit-serial square root, restoring divide.
// The pipeline advances only when en is high.
// ----------------------------------------------------------------------------
module vnr_unitize #(
  parameter int IN_W = 45,
  parameter int FRAC = vnr_pkg::FACE_FRAC,
  localparam int OUT_W = FRAC + 2
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [IN_W-1:0]  vec_in [3],
  output logic signed [OUT_W-1:0] vec_out [3],
  output logic                    zero_out
);

  localparam int MW  = vnr_pkg::UNIT_W;
  localparam int TOP = vnr_pkg::UNIT_TOP;
  localparam int SW  = vnr_pkg::SUMSQ_W;
  localparam int RW  = vnr_pkg::ROOT_W;
  localparam int NSQ = vnr_pkg::SQRT_STAGES;
  localparam int PW  = (IN_W > 1) ? $clog2(IN_W) : 1;
  localparam int XW  = IN_W + MW;
  localparam int QW  = FRAC + 1;
  localparam int DW  = RW + FRAC;

  // stage 0: magnitudes and max
  logic [IN_W-1:0] mag_c [3];
  logic [IN_W-1:0] max_c;
  logic [IN_W-1:0] s0_mag_r [3];
  logic [2:0]      s0_neg_r;
  logic [IN_W-1:0] s0_max_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec_in[i][IN_W-1] ? IN_W'(-vec_in[i]) : IN_W'(vec_in[i]);
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_mag_r[i] <= mag_c[i];
        s0_neg_r[i] <= vec_in[i][IN_W-1];
      end
      s0_max_r <= max_c;
    end
  end

  // stage 1: leading one of the max
  logic [PW-1:0]   pos_c;
  logic [IN_W-1:0] s1_mag_r [3];
  logic [2:0]      s1_neg_r;
  logic [PW-1:0]   s1_pos_r;
  logic            s1_zero_r;

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (s0_max_r[i]) pos_c = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r  <= s0_mag_r;
      s1_neg_r  <= s0_neg_r;
      s1_pos_r  <= pos_c;
      s1_zero_r <= (s0_max_r == '0);
    end
  end

  // stage 2: common shift so the max lands at the top bit
  logic [MW-1:0] shf_c [3];
  logic [MW-1:0] s2_m_r [3];
  logic [2:0]    s2_neg_r;
  logic          s2_zero_r;

  always_comb begin
    logic [XW-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      ext = XW'(s1_mag_r[i]);
      if (int'(s1_pos_r) >= TOP) begin
        ext = ext >> (int'(s1_pos_r) - TOP);
      end else begin
        ext = ext << (TOP - int'(s1_pos_r));
      end
      shf_c[i] = ext[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_m_r    <= shf_c;
      s2_neg_r  <= s1_neg_r;
      s2_zero_r <= s1_zero_r;
    end
  end

  // stage 3: squares
  logic [2*MW-1:0] s3_sq_r [3];
  logic [MW-1:0]   s3_m_r [3];
  logic [2:0]      s3_neg_r;
  logic            s3_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_sq_r[i] <= s2_m_r[i] * s2_m_r[i];
      end
      s3_m_r    <= s2_m_r;
      s3_neg_r  <= s2_neg_r;
      s3_zero_r <= s2_zero_r;
    end
  end

  // stage 4 feeds the root pipeline: sum of squares
  logic [SW-1:0] sq_rem_r  [NSQ+1];
  logic [RW-1:0] sq_root_r [NSQ+1];
  logic [MW-1:0] sq_m_r    [NSQ+1][3];
  logic [2:0]    sq_neg_r  [NSQ+1];
  logic          sq_zero_r [NSQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= SW'(s3_sq_r[0]) + SW'(s3_sq_r[1]) + SW'(s3_sq_r[2]);
      sq_root_r[0] <= '0;
      sq_m_r[0]    <= s3_m_r;
      sq_neg_r[0]  <= s3_neg_r;
      sq_zero_r[0] <= s3_zero_r;
    end
  end

  // one root bit per stage, remainder kept as n - root^2
  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    localparam int B = NSQ - 1 - g;
    logic [SW+1:0] trial;
    logic          take;
    always_comb begin
      trial = ((SW+2)'(sq_root_r[g]) << (B + 1)) | ((SW+2)'(1) << (2 * B));
      take  = ((SW+2)'(sq_rem_r[g]) >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[g+1]  <= take ? SW'((SW+2)'(sq_rem_r[g]) - trial) : sq_rem_r[g];
        sq_root_r[g+1] <= take ? (sq_root_r[g] | (RW'(1) << B)) : sq_root_r[g];
        sq_m_r[g+1]    <= sq_m_r[g];
        sq_neg_r[g+1]  <= sq_neg_r[g];
        sq_zero_r[g+1] <= sq_zero_r[g];
      end
    end
  end

  // dividend with half the length added for rounding
  logic [DW-1:0] dv_rem_r  [QW+1][3];
  logic [QW-1:0] dv_q_r    [QW+1][3];
  logic [RW-1:0] dv_len_r  [QW+1];
  logic [2:0]    dv_neg_r  [QW+1];
  logic          dv_zero_r [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= (DW'(sq_m_r[NSQ][i]) << FRAC) + DW'(sq_root_r[NSQ] >> 1);
        dv_q_r[0][i]   <= '0;
      end
      dv_len_r[0]  <= sq_root_r[NSQ];
      dv_neg_r[0]  <= sq_neg_r[NSQ];
      dv_zero_r[0] <= sq_zero_r[NSQ];
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int J = QW - 1 - g;
    logic [DW-1:0] dvs;
    assign dvs = DW'(dv_len_r[g]) << J;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_r[g][i] >= dvs) begin
            dv_rem_r[g+1][i] <= dv_rem_r[g][i] - dvs;
            dv_q_r[g+1][i]   <= dv_q_r[g][i] | (QW'(1) << J);
          end else begin
            dv_rem_r[g+1][i] <= dv_rem_r[g][i];
            dv_q_r[g+1][i]   <= dv_q_r[g][i];
          end
        end
        dv_len_r[g+1]  <= dv_len_r[g];
        dv_neg_r[g+1]  <= dv_neg_r[g];
        dv_zero_r[g+1] <= dv_zero_r[g];
      end
    end
  end

  // output: restore signs
  logic signed [OUT_W-1:0] out_r [3];
  logic                    zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[QW]) begin
          out_r[i] <= '0;
        end else if (dv_neg_r[QW][i]) begin
          out_r[i] <= -signed'(OUT_W'(dv_q_r[QW][i]));
        end else begin
          out_r[i] <= signed'(OUT_W'(dv_q_r[QW][i]));
        end
      end
      zero_r <= dv_zero_r[QW];
    end
  end

  assign vec_out  = out_r;
  assign zero_out = zero_r;

endmodule

@@ sv/vertex_normal_from_ring_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_normal_from_ring_unit
// Unit vertex normal from a center point and a ring of four neighbors.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one vertex and its four neighbors per
// transaction, each a packed x/y/z triple of signed COORD_WIDTH-bit values.
// Output channel (out_valid/out_ready): normal_x/y/z in signed fixed point
// with NORMAL_FRAC_BITS fraction bits, plus a degenerate flag when the summed
// face normals are zero (normal then reads zero).
// Throughput is one transaction per cycle while in_ready is high. Most of
// the pipeline depth lies in the two bit-per-stage square root and divider
// pipelines inside the face and final normalizers.
// The pipeline advances as one unit; a one-entry skid register behind the
// output register catches the item in flight when the receiver stalls, and
// in_ready drops only while that skid register is occupied.
// Reset is synchronous and clears all valid bits; data registers keep their
// contents. The block holds no state between transactions.
// ----------------------------------------------------------------------------
module vertex_normal_from_ring_unit #(
  parameter int COORD_WIDTH      = vnr_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = vnr_pkg::NORMAL_FRAC_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [vnr_pkg::POINT_WIDTH-1:0]         in_center_point,
  input  logic [vnr_pkg::POINT_WIDTH-1:0]         in_ring_0,
  input  logic [vnr_pkg::POINT_WIDTH-1:0]         in_ring_1,
  input  logic [vnr_pkg::POINT_WIDTH-1:0]         in_ring_2,
  input  logic [vnr_pkg::POINT_WIDTH-1:0]         in_ring_3,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [vnr_pkg::NORMAL_WIDTH-1:0] out_normal_x,
  output logic signed [vnr_pkg::NORMAL_WIDTH-1:0] out_normal_y,
  output logic signed [vnr_pkg::NORMAL_WIDTH-1:0] out_normal_z,
  output logic                                    out_degenerate
);

  localparam int CW      = COORD_WIDTH;
  localparam int DIFF_W  = CW + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int FACE_W  = vnr_pkg::FACE_FRAC + 2;
  localparam int ACC_W   = FACE_W + 2;
  localparam int FIN_W   = NORMAL_FRAC_BITS + 2;
  localparam int NW      = vnr_pkg::NORMAL_WIDTH;
  localparam int SAT_W   = (FIN_W > NW + 1) ? FIN_W : NW + 1;
  localparam int LAT     = 3 + (vnr_pkg::UNIT_BASE_LAT + vnr_pkg::FACE_FRAC) + 1
                         + (vnr_pkg::UNIT_BASE_LAT + NORMAL_FRAC_BITS) + 1;

  // output register with skid
  logic                 out_valid_r;
  logic signed [NW-1:0] out_n_r [3];
  logic                 out_deg_r;
  logic                 skid_v_r;
  logic signed [NW-1:0] skid_n_r [3];
  logic                 skid_deg_r;
  logic                 out_take;

  logic en;
  logic [LAT-1:0] vld_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage: unpack and offsets from the center
  logic [vnr_pkg::POINT_WIDTH-1:0] ring_c [4];
  logic signed [DIFF_W-1:0] diff_r [4][3];

  assign ring_c[0] = in_ring_0;
  assign ring_c[1] = in_ring_1;
  assign ring_c[2] = in_ring_2;
  assign ring_c[3] = in_ring_3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          diff_r[k][i] <= DIFF_W'(signed'(ring_c[k][i*CW +: CW]))
                        - DIFF_W'(signed'(in_center_point[i*CW +: CW]));
        end
      end
    end
  end

  // stage: cross product terms
  logic signed [PROD_W-1:0] prod_r [4][6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k][0] <= diff_r[k][1] * diff_r[(k+1)%4][2];
        prod_r[k][1] <= diff_r[k][2] * diff_r[(k+1)%4][1];
        prod_r[k][2] <= diff_r[k][2] * diff_r[(k+1)%4][0];
        prod_r[k][3] <= diff_r[k][0] * diff_r[(k+1)%4][2];
        prod_r[k][4] <= diff_r[k][0] * diff_r[(k+1)%4][1];
        prod_r[k][5] <= diff_r[k][1] * diff_r[(k+1)%4][0];
      end
    end
  end

  // stage: face normals
  logic signed [CROSS_W-1:0] cross_r [4][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          cross_r[k][i] <= CROSS_W'(prod_r[k][2*i]) - CROSS_W'(prod_r[k][2*i+1]);
        end
      end
    end
  end

  logic signed [FACE_W-1:0] face_c [4][3];
  logic [3:0]               face_zero_c;

  for (genvar k = 0; k < 4; k++) begin : g_face
    vnr_unitize #(
      .IN_W (CROSS_W),
      .FRAC (vnr_pkg::FACE_FRAC)
    ) u_face (
      .clk      (clk),
      .en       (en),
      .vec_in   (cross_r[k]),
      .vec_out  (face_c[k]),
      .zero_out (face_zero_c[k])
    );
  end

  // zero faces already come out as zero vectors
  logic signed [ACC_W-1:0] acc_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= ACC_W'(face_c[0][i]) + ACC_W'(face_c[1][i])
                  + ACC_W'(face_c[2][i]) + ACC_W'(face_c[3][i]);
      end
    end
  end

  logic signed [FIN_W-1:0] fin_c [3];
  logic                    fin_zero_c;

  vnr_unitize #(
    .IN_W (ACC_W),
    .FRAC (NORMAL_FRAC_BITS)
  ) u_final (
    .clk      (clk),
    .en       (en),
    .vec_in   (acc_r),
    .vec_out  (fin_c),
    .zero_out (fin_zero_c)
  );

  // saturate into the output width
  logic signed [NW-1:0] pipe_n_r [3];
  logic                 pipe_deg_r;

  always_ff @(posedge clk) begin
    logic signed [SAT_W-1:0] ext;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ext = SAT_W'(fin_c[i]);
        if (ext > SAT_W'(32767)) begin
          pipe_n_r[i] <= NW'(32767);
        end else if (ext < -SAT_W'(32768)) begin
          pipe_n_r[i] <= NW'(-32768);
        end else begin
          pipe_n_r[i] <= ext[NW-1:0];
        end
      end
      pipe_deg_r <= fin_zero_c;
    end
  end

  assign out_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_take) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        out_n_r     <= skid_n_r;
        out_deg_r   <= skid_deg_r;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= vld_r[LAT-1];
        out_n_r     <= pipe_n_r;
        out_deg_r   <= pipe_deg_r;
      end
    end else if (en && vld_r[LAT-1]) begin
      skid_v_r   <= 1'b1;
      skid_n_r   <= pipe_n_r;
      skid_deg_r <= pipe_deg_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = out_n_r[0];
  assign out_normal_y   = out_n_r[1];
  assign out_normal_z   = out_n_r[2];
  assign out_degenerate = out_deg_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0)
    else $error("regular result with zero normal");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && !out_ready && vld_r[LAT-1]))
    else $error("skid filled without a stalled result");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives vertex/ring transactions into vertex_normal_from_ring_unit with
// random idling on both sides. An integer model of the face-normal averaging
// predicts each unit normal, and the monitor compares every output
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = vnr_pkg::COORD_WIDTH_DEF;
  localparam int NFRAC     = vnr_pkg::NORMAL_FRAC_DEF;
  localparam int PTW       = vnr_pkg::POINT_WIDTH;
  localparam int NW        = vnr_pkg::NORMAL_WIDTH;
  localparam int N_RANDOM  = 725;
  localparam int QUIET_TAIL = 150;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_LIMIT = 4000;

  typedef logic [PTW-1:0] point_t;

  typedef struct {
    point_t center;
    point_t ring [4];
    bit     drain_first;
  } vertex_t;

  typedef struct {
    logic signed [NW-1:0] nx, ny, nz;
    logic                 degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  point_t in_center_point = '0;
  point_t in_ring_0 = '0, in_ring_1 = '0, in_ring_2 = '0, in_ring_3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  vertex_t pending_vertices [$];
  normal_t expected_normals [$];
  int      errors = 0;
  int      vertices_taken = 0;
  logic    in_taken = 1'b0;
  bit      stim_done = 1'b0;

  always #5 clk = ~clk;

  vertex_normal_from_ring_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_center_point(in_center_point),
    .in_ring_0(in_ring_0), .in_ring_1(in_ring_1),
    .in_ring_2(in_ring_2), .in_ring_3(in_ring_3),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  // ---------------- normal predictor ----------------

  function automatic longint coord(point_t p, int idx);
    logic signed [CW-1:0] raw;
    raw = p[idx*CW +: CW];
    return longint'(raw);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] n);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale to unit length with frac fraction bits, 0 when the vector is zero
  function automatic bit to_unit(input longint v [3], input int frac,
                                 output longint u [3]);
    bit [63:0] m [3];
    bit [63:0] mx, len, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b0;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    len = int_sqrt(m[0]*m[0] + m[1]*m[1] + m[2]*m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << frac) + (len >> 1)) / len;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic logic signed [NW-1:0] sat16(longint x);
    if (x > 32767) return 16'sd32767;
    if (x < -32768) return -16'sd32768;
    return x[NW-1:0];
  endfunction

  function automatic normal_t average_normal(vertex_t vx);
    longint d [4][3];
    longint a [3], b [3], cr [3], face [3], acc [3], unit [3];
    normal_t r;
    for (int i = 0; i < 3; i++) acc[i] = 0;
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 3; i++)
        d[k][i] = coord(vx.ring[k], i) - coord(vx.center, i);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = d[k][i];
        b[i] = d[(k+1) % 4][i];
      end
      cr[0] = a[1]*b[2] - a[2]*b[1];
      cr[1] = a[2]*b[0] - a[0]*b[2];
      cr[2] = a[0]*b[1] - a[1]*b[0];
      void'(to_unit(cr, vnr_pkg::FACE_FRAC, face));
      for (int i = 0; i < 3; i++) acc[i] += face[i];
    end
    if (!to_unit(acc, NFRAC, unit)) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
    end else begin
      r.nx = sat16(unit[0]); r.ny = sat16(unit[1]); r.nz = sat16(unit[2]);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  // ---------------- stimulus ----------------

  // the three coordinates fill every bit of the point, so top is shifted out
  function automatic point_t pack(longint x, longint y, longint z, bit [31:0] top);
    point_t p;
    p = point_t'(64'(top) << (3*CW));
    p[0 +: CW]    = x[CW-1:0];
    p[CW +: CW]   = y[CW-1:0];
    p[2*CW +: CW] = z[CW-1:0];
    return p;
  endfunction

  function automatic point_t rand_point();
    return point_t'({$urandom, $urandom});
  endfunction

  function automatic longint rand_coord(int span);
    return longint'($urandom_range(2*span, 0)) - span;
  endfunction

  task automatic add_vertex(point_t c, point_t r0, point_t r1, point_t r2, point_t r3,
                            bit drain);
    vertex_t vx;
    vx.center = c;
    vx.ring[0] = r0; vx.ring[1] = r1; vx.ring[2] = r2; vx.ring[3] = r3;
    vx.drain_first = drain;
    pending_vertices.push_back(vx);
  endtask

  // grid-like neighborhood: equal x/y steps around the center, random heights
  task automatic add_grid_vertex(int step, int zspan, bit drain);
    longint cx, cy, cz;
    point_t r [4];
    cx = rand_coord(1 << (CW-1));
    cy = rand_coord(1 << (CW-1));
    cz = rand_coord(1 << (CW-1));
    r[0] = pack(cx + step, cy, cz + rand_coord(zspan), $urandom);
    r[1] = pack(cx, cy + step, cz + rand_coord(zspan), $urandom);
    r[2] = pack(cx - step, cy, cz + rand_coord(zspan), $urandom);
    r[3] = pack(cx, cy - step, cz + rand_coord(zspan), $urandom);
    add_vertex(pack(cx, cy, cz, $urandom), r[0], r[1], r[2], r[3], drain);
  endtask

  initial begin
    longint mx, mn;
    int kind, step;
    mx = (1 << (CW-1)) - 1;
    mn = -(1 << (CW-1));
    // all points equal: every face zero, degenerate
    add_vertex('0, '0, '0, '0, '0, 1'b0);
    add_vertex('1, '1, '1, '1, '1, 1'b0);
    // flat unit grid, normal straight up
    add_vertex(pack(0,0,0,0), pack(1,0,0,0), pack(0,1,0,0), pack(-1,0,0,0),
               pack(0,-1,0,0), 1'b0);
    // reversed order, normal down
    add_vertex(pack(0,0,0,0), pack(0,-1,0,0), pack(-1,0,0,0), pack(0,1,0,0),
               pack(1,0,0,0), 1'b0);
    // all neighbors on one line: zero sum
    add_vertex(pack(0,0,0,0), pack(5,0,0,0), pack(-3,0,0,0), pack(7,0,0,0),
               pack(-9,0,0,0), 1'b0);
    // one coincident neighbor: two zero faces
    add_vertex(pack(10,10,10,0), pack(10,10,10,0), pack(10,11,10,0),
               pack(9,10,12,0), pack(10,9,10,0), 1'b0);
    // extremes of the coordinate range
    add_vertex(pack(mn,mn,mn,0), pack(mx,mn,mx,0), pack(mn,mx,mn,0),
               pack(mx,mx,mx,0), pack(mx,mn,mn,0), 1'b0);
    add_vertex(pack(mx,mx,mx,'1), pack(mn,mx,mn,'1), pack(mx,mn,mx,'1),
               pack(mn,mn,mn,'1), pack(mn,mx,mx,'1), 1'b0);
    add_vertex(pack(mn,0,mx,0), pack(mx,0,mn,0), pack(mn,mx,0,0), pack(0,mn,mx,0),
               pack(mx,mx,mn,0), 1'b0);
    // steep slopes along each axis
    add_vertex(pack(0,0,0,0), pack(1,0,mx,0), pack(0,1,0,0), pack(-1,0,mn,0),
               pack(0,-1,0,0), 1'b0);
    add_vertex(pack(0,0,0,0), pack(1,0,0,0), pack(0,1,mx,0), pack(-1,0,0,0),
               pack(0,-1,mn,0), 1'b0);
    for (int i = 0; i < 12; i++)
      add_vertex(rand_point(), rand_point(), rand_point(), rand_point(), rand_point(),
                 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(9, 0);
      step = (kind < 3) ? 1 : $urandom_range(1 << 12, 1);
      if (kind < 7)
        add_grid_vertex(step, (kind % 2) ? (1 << $urandom_range(20, 0)) : 4,
                        i == N_RANDOM/2);
      else
        add_vertex(rand_point(), rand_point(), rand_point(), rand_point(), rand_point(),
                   i == N_RANDOM/2);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_vertices.size() == 0 && !in_valid);
    wait (expected_normals.size() == 0);
    repeat (200) @(posedge clk);
    if (expected_normals.size() != 0) begin
      $error("%0d normals never arrived", expected_normals.size());
      errors++;
    end
    stim_done = 1'b1;
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // ---------------- driver ----------------

  int send_gap = 0;

  always @(negedge clk) begin
    vertex_t vx;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_vertices.size() != 0 &&
                   !(pending_vertices[0].drain_first && expected_normals.size() != 0)) begin
        vx = pending_vertices.pop_front();
        in_center_point <= vx.center;
        in_ring_0 <= vx.ring[0];
        in_ring_1 <= vx.ring[1];
        in_ring_2 <= vx.ring[2];
        in_ring_3 <= vx.ring[3];
        in_valid <= 1'b1;
        if (pending_vertices.size() > QUIET_TAIL && $urandom_range(7, 0) == 0)
          send_gap <= $urandom_range(17, 1);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------

  int  recv_gap = 0;
  bit  long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && vertices_taken >= 200) begin
      // stall long enough to back the whole pipeline up
      long_hold_done <= 1'b1;
      recv_gap <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (pending_vertices.size() > QUIET_TAIL && $urandom_range(7, 0) == 0)
        recv_gap <= $urandom_range(17, 1);
    end
  end

  // ---------------- monitor and scoreboard ----------------

  int idle_cycles = 0;

  always @(posedge clk) begin
    vertex_t vx;
    normal_t exp_n;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      vx.center = in_center_point;
      vx.ring[0] = in_ring_0; vx.ring[1] = in_ring_1;
      vx.ring[2] = in_ring_2; vx.ring[3] = in_ring_3;
      vx.drain_first = 1'b0;
      expected_normals.push_back(average_normal(vx));
      vertices_taken <= vertices_taken + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected output transaction");
        errors++;
      end else begin
        exp_n = expected_normals.pop_front();
        if (out_normal_x !== exp_n.nx) begin
          $error("normal_x expected %0d actual %0d", exp_n.nx, out_normal_x);
          errors++;
        end
        if (out_normal_y !== exp_n.ny) begin
          $error("normal_y expected %0d actual %0d", exp_n.ny, out_normal_y);
          errors++;
        end
        if (out_normal_z !== exp_n.nz) begin
          $error("normal_z expected %0d actual %0d", exp_n.nz, out_normal_z);
          errors++;
        end
        if (out_degenerate !== exp_n.degen) begin
          $error("degenerate expected %0d actual %0d", exp_n.degen, out_degenerate);
          errors++;
        end
      end
    end
    // watchdog on cycles with no transaction on either side
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

@@ sim.f @@
sv/vnr_pkg.sv
sv/vnr_unitize.sv
sv/vertex_normal_from_ring_unit.sv
sim/testbench.sv
